FILE: hw/rtl/plm_pkg.sv
// ============================================================================
// Per-source packet limiter package
// Shared constants, table entry layout and the result item structure.
// ============================================================================
`default_nettype none

package plm_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int PROBE_W       = $clog2(TABLE_ENTRIES + 1);

  localparam int LEN_W   = 16;
  localparam int ETYPE_W = 16;
  localparam int KEY_W   = 32;
  localparam int COUNT_W = 16;
  localparam int TOTAL_W = 64;

  localparam logic [LEN_W-1:0]   MIN_FRAME_BYTES = 16'd34;
  localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4  = 16'h0800;
  localparam logic [COUNT_W-1:0] LIMIT_AT_RESET  = 16'd100;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } plm_entry_t;

  localparam int ENTRY_W = $bits(plm_entry_t);

  typedef struct packed {
    logic               drop;
    logic               checked;
    logic               table_full;
    logic [TOTAL_W-1:0] seen_total;
    logic [TOTAL_W-1:0] dropped_total;
  } plm_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/per_source_packet_limiter_core.sv
// ============================================================================
// Per-source packet limiter core
// Counts IPv4 frames per source address and flags sources over their limit.
// ============================================================================
// One header item enters on the input channel (in_valid/in_stall) and exactly
// one result item leaves on the output channel (out_valid/out_stall). The
// packet_limit register is written through cfg_we/cfg_wdata; the user must
// write it only while idle, the block does not enforce this. Sources live in
// a hashed table with linear probing, one RAM read per cycle. Short or
// non-IPv4 frames go straight to the emit state; a checked frame first probes
// entries one by one in the probe state (1 for most items, up to the table
// depth when nearly full). Items are worked one at a time, so the next item
// is accepted in the cycle after the result moves to the output register.
// After reset the block clears the table, one entry per cycle, over all
// TABLE_ENTRIES (1024) entries with in_stall high; totals reset to zero and
// packet_limit to 100. While the receiver stalls, the output register holds
// its item and the engine can take and work on one more item, then waits.
// ============================================================================
`default_nettype none

module per_source_packet_limiter_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [plm_pkg::COUNT_W-1:0]   cfg_wdata,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [plm_pkg::LEN_W-1:0]     frame_length,
  input  wire logic [plm_pkg::ETYPE_W-1:0]   ether_type,
  input  wire logic [plm_pkg::KEY_W-1:0]     source_address,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic                          drop,
  output      logic                          checked,
  output      logic                          table_full,
  output      logic [plm_pkg::TOTAL_W-1:0]   seen_total,
  output      logic [plm_pkg::TOTAL_W-1:0]   dropped_total
);

  logic                         res_valid;
  logic                         res_ready;
  plm_pkg::plm_result_t         res;
  plm_pkg::plm_result_t         out_item;
  logic                         ram_we;
  logic [plm_pkg::IDX_W-1:0]    ram_waddr;
  plm_pkg::plm_entry_t          ram_wdata;
  logic                         ram_re;
  logic [plm_pkg::IDX_W-1:0]    ram_raddr;
  plm_pkg::plm_entry_t          ram_rdata;

  plm_ram #(
    .WIDTH (plm_pkg::ENTRY_W),
    .DEPTH (plm_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  plm_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .frame_length   (frame_length),
    .ether_type     (ether_type),
    .source_address (source_address),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata)
  );

  plm_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign drop          = out_item.drop;
  assign checked       = out_item.checked;
  assign table_full    = out_item.table_full;
  assign seen_total    = out_item.seen_total;
  assign dropped_total = out_item.dropped_total;

endmodule

`default_nettype wire

FILE: hw/rtl/plm_ram.sv
// ============================================================================
// Per-source packet limiter table RAM
// Single write port, single read port, registered read data.
// ============================================================================
`default_nettype none

module plm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/plm_engine.sv
// ============================================================================
// Per-source packet limiter engine
// Clears the table after reset, then probes it for each checked item and updates it.
// ============================================================================
`default_nettype none

module plm_engine (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [plm_pkg::COUNT_W-1:0]         cfg_wdata,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic [plm_pkg::LEN_W-1:0]           frame_length,
  input  wire logic [plm_pkg::ETYPE_W-1:0]         ether_type,
  input  wire logic [plm_pkg::KEY_W-1:0]           source_address,
  output      logic                                res_valid,
  input  wire logic                                res_ready,
  output      plm_pkg::plm_result_t                res,
  output      logic                                ram_we,
  output      logic [plm_pkg::IDX_W-1:0]           ram_waddr,
  output      plm_pkg::plm_entry_t                 ram_wdata,
  output      logic                                ram_re,
  output      logic [plm_pkg::IDX_W-1:0]           ram_raddr,
  input  wire plm_pkg::plm_entry_t                 ram_rdata
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_PROBE = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  localparam logic [plm_pkg::IDX_W-1:0]   LAST_IDX = plm_pkg::IDX_W'(plm_pkg::TABLE_ENTRIES - 1);
  localparam logic [plm_pkg::IDX_W:0]     ENTRIES_EXT =
    (plm_pkg::IDX_W + 1)'(plm_pkg::TABLE_ENTRIES);
  localparam logic [plm_pkg::PROBE_W-1:0] ENTRIES_PROBE =
    plm_pkg::PROBE_W'(plm_pkg::TABLE_ENTRIES);

  function automatic logic [plm_pkg::IDX_W-1:0] hash_index(
    input logic [plm_pkg::KEY_W-1:0] k
  );
    logic [plm_pkg::IDX_W-1:0] h;
    h = '0;
    for (int i = 0; i < plm_pkg::KEY_W; i++) begin
      h[i % plm_pkg::IDX_W] = h[i % plm_pkg::IDX_W] ^ k[i];
    end
    if ({1'b0, h} >= ENTRIES_EXT) begin
      h = h - ENTRIES_EXT[plm_pkg::IDX_W-1:0];
    end
    return h;
  endfunction

  state_t                         state;
  state_t                         state_next;
  logic [plm_pkg::IDX_W-1:0]      clr_idx;
  logic [plm_pkg::IDX_W-1:0]      probe_idx;
  logic [plm_pkg::IDX_W-1:0]      next_idx;
  logic [plm_pkg::PROBE_W-1:0]    probe_cnt;
  logic [plm_pkg::KEY_W-1:0]      key;
  logic [plm_pkg::COUNT_W-1:0]    limit;
  logic [plm_pkg::TOTAL_W-1:0]    seen_counter;
  logic [plm_pkg::TOTAL_W-1:0]    dropped_counter;
  logic [plm_pkg::TOTAL_W-1:0]    dropped_inc;
  logic [plm_pkg::IDX_W-1:0]      in_hash;
  logic                           in_checked;
  logic                           hit;
  logic                           over;
  logic                           exhausted;
  logic                           resolve;

  assign in_hash    = hash_index(source_address);
  assign in_checked = (frame_length >= plm_pkg::MIN_FRAME_BYTES) &&
                      (ether_type == plm_pkg::ETHERTYPE_IPV4);
  assign next_idx   = (probe_idx == LAST_IDX) ? '0 : probe_idx + plm_pkg::IDX_W'(1);
  assign hit        = ram_rdata.valid && (ram_rdata.key == key);
  assign over       = ram_rdata.count >= limit;
  assign exhausted  = probe_cnt == ENTRIES_PROBE;
  assign resolve    = hit || !ram_rdata.valid || exhausted;
  assign dropped_inc = dropped_counter + plm_pkg::TOTAL_W'(1);

  assign in_stall  = (state != ST_IDLE);
  assign res_valid = (state == ST_EMIT);

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = probe_idx;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = next_idx;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        if (clr_idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_checked) begin
            ram_re     = 1'b1;
            ram_raddr  = in_hash;
            state_next = ST_PROBE;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_PROBE: begin
        if (hit) begin
          if (!over) begin
            ram_we    = 1'b1;
            ram_wdata = '{valid: 1'b1, key: key,
                          count: ram_rdata.count + plm_pkg::COUNT_W'(1)};
          end
        end else if (!ram_rdata.valid) begin
          ram_we    = 1'b1;
          ram_wdata = '{valid: 1'b1, key: key, count: plm_pkg::COUNT_W'(1)};
        end else if (!exhausted) begin
          ram_re = 1'b1;
        end
        if (resolve) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_idx         <= '0;
      limit           <= plm_pkg::LIMIT_AT_RESET;
      seen_counter    <= '0;
      dropped_counter <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + plm_pkg::IDX_W'(1);
        end
        ST_IDLE: begin
          if (in_valid) begin
            key       <= source_address;
            probe_idx <= in_hash;
            probe_cnt <= plm_pkg::PROBE_W'(1);
            if (in_checked) begin
              seen_counter <= seen_counter + plm_pkg::TOTAL_W'(1);
            end else begin
              res <= '{drop: 1'b0, checked: 1'b0, table_full: 1'b0,
                       seen_total: seen_counter, dropped_total: dropped_counter};
            end
          end
        end
        ST_PROBE: begin
          if (hit) begin
            res <= '{drop: over, checked: 1'b1, table_full: 1'b0,
                     seen_total: seen_counter,
                     dropped_total: over ? dropped_inc : dropped_counter};
            if (over) begin
              dropped_counter <= dropped_inc;
            end
          end else if (!ram_rdata.valid) begin
            res <= '{drop: 1'b0, checked: 1'b1, table_full: 1'b0,
                     seen_total: seen_counter, dropped_total: dropped_counter};
          end else if (exhausted) begin
            res <= '{drop: 1'b0, checked: 1'b1, table_full: 1'b1,
                     seen_total: seen_counter, dropped_total: dropped_counter};
          end else begin
            probe_idx <= next_idx;
            probe_cnt <= probe_cnt + plm_pkg::PROBE_W'(1);
          end
        end
        ST_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/plm_out_stage.sv
// ============================================================================
// Per-source packet limiter output stage
// Holds one result item for the receiver while the engine moves on.
// ============================================================================
`default_nettype none

module plm_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 res_valid,
  output      logic                 res_ready,
  input  wire plm_pkg::plm_result_t res,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      plm_pkg::plm_result_t out_item
);

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/plm_checker.sv
// ============================================================================
// Per-source packet limiter checker
// Port-level properties of the core, attached by bind.
// ============================================================================
`default_nettype none

module plm_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          drop,
  input wire logic                          checked,
  input wire logic                          table_full,
  input wire logic [plm_pkg::TOTAL_W-1:0]   seen_total,
  input wire logic [plm_pkg::TOTAL_W-1:0]   dropped_total
);

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input not stalled during table clearing");

  a_flags_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid && (drop || table_full) |-> checked && !(drop && table_full))
    else $error("inconsistent result flags");

  a_result_follows_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without the engine being busy");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(seen_total) &&
      $stable(dropped_total) && $stable(drop))
    else $error("stalled result item changed");

endmodule

bind per_source_packet_limiter_core plm_checker u_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the per-source packet limiter core
// Sends frame headers through the valid/stall handshake and predicts each
// verdict from a model of the source table. Every result item is compared
// field by field with its prediction. The run covers several packet limits,
// random sender gaps and receiver stalls, and it fills the table until new
// sources are refused.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int          POOL_SIZE   = 48;
  localparam int          SETTLE      = 4;
  localparam logic [plm_pkg::ETYPE_W-1:0] ETHERTYPE_ARP  = 16'h0806;
  localparam logic [plm_pkg::ETYPE_W-1:0] ETHERTYPE_IPV6 = 16'h86DD;

  class limiter_scoreboard;
    plm_pkg::plm_result_t        expected_verdicts[$];
    logic [plm_pkg::COUNT_W-1:0] source_count[bit [plm_pkg::KEY_W-1:0]];
    logic [plm_pkg::COUNT_W-1:0] limit;
    logic [plm_pkg::TOTAL_W-1:0] seen;
    logic [plm_pkg::TOTAL_W-1:0] dropped;
    int                          errors;

    function new();
      limit   = plm_pkg::LIMIT_AT_RESET;
      seen    = '0;
      dropped = '0;
      errors  = 0;
    endfunction

    function void set_limit(logic [plm_pkg::COUNT_W-1:0] value);
      limit = value;
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    function int occupancy();
      return source_count.num();
    endfunction

    function bit is_known(logic [plm_pkg::KEY_W-1:0] src);
      return source_count.exists(src);
    endfunction

    function void note_header(logic [plm_pkg::LEN_W-1:0] len,
                              logic [plm_pkg::ETYPE_W-1:0] etype,
                              logic [plm_pkg::KEY_W-1:0] src);
      plm_pkg::plm_result_t verdict;
      verdict = '0;
      if (len >= plm_pkg::MIN_FRAME_BYTES && etype == plm_pkg::ETHERTYPE_IPV4) begin
        verdict.checked = 1'b1;
        seen = seen + plm_pkg::TOTAL_W'(1);
        if (source_count.exists(src)) begin
          if (source_count[src] >= limit) begin
            verdict.drop = 1'b1;
            dropped = dropped + plm_pkg::TOTAL_W'(1);
          end else begin
            source_count[src] = source_count[src] + plm_pkg::COUNT_W'(1);
          end
        end else if (source_count.num() < plm_pkg::TABLE_ENTRIES) begin
          source_count[src] = plm_pkg::COUNT_W'(1);
        end else begin
          verdict.table_full = 1'b1;
        end
      end
      verdict.seen_total    = seen;
      verdict.dropped_total = dropped;
      expected_verdicts.push_back(verdict);
    endfunction

    function void compare(string field, logic [plm_pkg::TOTAL_W-1:0] want,
                          logic [plm_pkg::TOTAL_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_verdict(plm_pkg::plm_result_t got);
      plm_pkg::plm_result_t want;
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t: result item arrived with nothing expected, actual %p", $time, got);
        return;
      end
      want = expected_verdicts.pop_front();
      compare("drop", plm_pkg::TOTAL_W'(want.drop), plm_pkg::TOTAL_W'(got.drop));
      compare("checked", plm_pkg::TOTAL_W'(want.checked), plm_pkg::TOTAL_W'(got.checked));
      compare("table_full", plm_pkg::TOTAL_W'(want.table_full),
              plm_pkg::TOTAL_W'(got.table_full));
      compare("seen_total", want.seen_total, got.seen_total);
      compare("dropped_total", want.dropped_total, got.dropped_total);
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_we;
  logic [plm_pkg::COUNT_W-1:0] cfg_wdata;
  logic                        in_valid;
  logic                        in_stall;
  logic [plm_pkg::LEN_W-1:0]   frame_length;
  logic [plm_pkg::ETYPE_W-1:0] ether_type;
  logic [plm_pkg::KEY_W-1:0]   source_address;
  logic                        out_valid;
  logic                        out_stall;
  logic                        drop;
  logic                        checked;
  logic                        table_full;
  logic [plm_pkg::TOTAL_W-1:0] seen_total;
  logic [plm_pkg::TOTAL_W-1:0] dropped_total;

  limiter_scoreboard           sb = new();
  logic [plm_pkg::KEY_W-1:0]   source_pool[POOL_SIZE];
  bit                          tx_quiet = 1'b0;
  bit                          rx_quiet = 1'b0;
  int unsigned                 cycle_count = 0;

  per_source_packet_limiter_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .frame_length   (frame_length),
    .ether_type     (ether_type),
    .source_address (source_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drop           (drop),
    .checked        (checked),
    .table_full     (table_full),
    .seen_total     (seen_total),
    .dropped_total  (dropped_total)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = rx_quiet ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
      sb.check_verdict(plm_pkg::plm_result_t'({drop, checked, table_full, seen_total,
                                               dropped_total}));
    end
  end

  task automatic send_header(input logic [plm_pkg::LEN_W-1:0] len,
                             input logic [plm_pkg::ETYPE_W-1:0] etype,
                             input logic [plm_pkg::KEY_W-1:0] src);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    frame_length   <= len;
    ether_type     <= etype;
    source_address <= src;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_header(len, etype, src);
  endtask

  task automatic apply_packet_limit(input logic [plm_pkg::COUNT_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(value);
  endtask

  function automatic logic [plm_pkg::KEY_W-1:0] fresh_source();
    logic [plm_pkg::KEY_W-1:0] src;
    do src = $urandom(); while (sb.is_known(src));
    return src;
  endfunction

  function automatic logic [plm_pkg::LEN_W-1:0] full_length();
    if ($urandom_range(0, 3) == 0) begin
      return ($urandom_range(0, 1) == 0) ? plm_pkg::MIN_FRAME_BYTES : {plm_pkg::LEN_W{1'b1}};
    end
    return plm_pkg::LEN_W'($urandom_range(plm_pkg::MIN_FRAME_BYTES, 2**plm_pkg::LEN_W - 1));
  endfunction

  task automatic send_random_header();
    int unsigned                 kind;
    int unsigned                 pick;
    logic [plm_pkg::ETYPE_W-1:0] etype;
    logic [plm_pkg::KEY_W-1:0]   src;
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      src = source_pool[$urandom_range(0, 3)];
    end else if (pick < 90) begin
      src = source_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else begin
      src = $urandom();
    end
    if (kind < 80) begin
      send_header(full_length(), plm_pkg::ETHERTYPE_IPV4, src);
    end else if (kind < 90) begin
      etype = ($urandom_range(0, 1) == 0) ? plm_pkg::ETHERTYPE_IPV4 :
              plm_pkg::ETYPE_W'($urandom());
      send_header(plm_pkg::LEN_W'($urandom_range(0, plm_pkg::MIN_FRAME_BYTES - 1)),
                  etype, src);
    end else begin
      case ($urandom_range(0, 3))
        0: etype = ETHERTYPE_ARP;
        1: etype = ETHERTYPE_IPV6;
        2: etype = plm_pkg::ETHERTYPE_IPV4 ^ 16'h0001;
        default: do etype = plm_pkg::ETYPE_W'($urandom());
                 while (etype == plm_pkg::ETHERTYPE_IPV4);
      endcase
      send_header(plm_pkg::LEN_W'($urandom()), etype, src);
    end
  endtask

  initial begin : stimulus
    logic [plm_pkg::COUNT_W-1:0] limit_plan[6];
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    frame_length   <= '0;
    ether_type     <= '0;
    source_address <= '0;
    limit_plan = '{16'd7, 16'hFFFF, 16'd2, 16'd1, 16'd150, 16'd4};
    source_pool[0] = '0;
    source_pool[1] = '1;
    source_pool[2] = 32'hC0A8_0001;
    source_pool[3] = 32'h0A00_0001;
    for (int i = 4; i < POOL_SIZE; i++) source_pool[i] = $urandom();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset limit: short frames, non-IPv4 frames, new and repeated sources.
    send_header('0, plm_pkg::ETHERTYPE_IPV4, source_pool[3]);
    send_header(plm_pkg::MIN_FRAME_BYTES - 1, plm_pkg::ETHERTYPE_IPV4, source_pool[3]);
    send_header(plm_pkg::MIN_FRAME_BYTES, plm_pkg::ETHERTYPE_IPV4 ^ 16'h0001, source_pool[3]);
    send_header('1, '1, '1);
    send_header(plm_pkg::MIN_FRAME_BYTES, plm_pkg::ETHERTYPE_IPV4, '0);
    send_header('1, plm_pkg::ETHERTYPE_IPV4, '1);
    send_header(plm_pkg::MIN_FRAME_BYTES, plm_pkg::ETHERTYPE_IPV4, '0);
    send_header(16'd1500, ETHERTYPE_IPV6, '0);
    send_header(16'd64, plm_pkg::ETHERTYPE_IPV4, 32'h0000_0001);
    send_header(16'd64, '0, 32'h0000_0001);

    // A limit of one drops every repeat of a known source.
    apply_packet_limit(16'd1);
    send_header(16'd64, plm_pkg::ETHERTYPE_IPV4, '0);
    send_header(16'd64, plm_pkg::ETHERTYPE_IPV4, '1);
    send_header(16'd64, plm_pkg::ETHERTYPE_IPV4, source_pool[2]);
    send_header(16'd64, plm_pkg::ETHERTYPE_IPV4, source_pool[2]);
    send_header(16'd64, plm_pkg::ETHERTYPE_IPV4, 32'h0000_0001);

    apply_packet_limit('1);
    send_header(16'd64, plm_pkg::ETHERTYPE_IPV4, '0);
    send_header('1, plm_pkg::ETHERTYPE_IPV4, source_pool[2]);

    foreach (limit_plan[p]) begin
      apply_packet_limit(limit_plan[p]);
      for (int i = 0; i < 16; i++) begin
        if (i % 8 == 0) begin
          tx_quiet = ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        send_random_header();
      end
    end

    // Fill every free entry with new sources so that later ones are refused.
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    apply_packet_limit(16'($urandom_range(1, 20)));
    while (sb.occupancy() < plm_pkg::TABLE_ENTRIES) begin
      if ($urandom_range(0, 19) == 0) begin
        send_random_header();
      end else begin
        send_header(full_length(), plm_pkg::ETHERTYPE_IPV4, fresh_source());
      end
    end

    apply_packet_limit(16'd3);
    for (int i = 0; i < 30; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        send_header(full_length(), plm_pkg::ETHERTYPE_IPV4, fresh_source());
      end else begin
        send_random_header();
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
